FILE: design/wmmf_pkg.sv
// Shared types and constants for the 3x3 min/max window filter.
package wmmf_pkg;

  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;

  localparam int PIX_W     = 8;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;

  localparam int RESET_FRAME_WIDTH  = 176;
  localparam int RESET_FRAME_HEIGHT = 144;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;
  localparam logic [PIX_W-1:0] PIX_MIN = 8'h00;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  typedef logic [PIX_W-1:0] pix_t;

  // one window column, index 0 is the oldest row
  typedef pix_t [2:0] pcol_t;
  // three columns, index 0 is the leftmost
  typedef pcol_t [2:0] win_t;

  typedef struct packed {
    logic [2:0] rows;
    logic [2:0] cols;
  } nb_mask_t;

  // centres one pixel can release, in raster order
  typedef enum logic [1:0] {
    RES_UP_MID   = 2'd0,
    RES_UP_LAST  = 2'd1,
    RES_LOW_MID  = 2'd2,
    RES_LOW_LAST = 2'd3
  } res_kind_t;

endpackage

FILE: design/wmmf_line_ram.sv
// Line store RAM: one write port, one registered read port.
module wmmf_line_ram #(
  parameter int DEPTH  = 256,
  parameter int DATA_W = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: design/wmmf_kernel.sv
// Masked minimum and maximum over a 3x3 window.
module wmmf_kernel import wmmf_pkg::*; (
  input  win_t     win,
  input  nb_mask_t mask,
  output pix_t     min_value,
  output pix_t     max_value
);

  pix_t col_min [3];
  pix_t col_max [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      col_min[k] = PIX_MAX;
      col_max[k] = PIX_MIN;
      for (int j = 0; j < 3; j++) begin
        if (mask.rows[j] && mask.cols[k]) begin
          if (win[k][j] < col_min[k]) col_min[k] = win[k][j];
          if (win[k][j] > col_max[k]) col_max[k] = win[k][j];
        end
      end
    end
  end

  always_comb begin
    min_value = col_min[0];
    max_value = col_max[0];
    for (int k = 1; k < 3; k++) begin
      if (col_min[k] < min_value) min_value = col_min[k];
      if (col_max[k] > max_value) max_value = col_max[k];
    end
  end

endmodule

FILE: design/window_min_max_filter_3x3_unit.sv
// Top level of the 3x3 min/max window filter (grayscale erosion and dilation).
//
// Pixels enter in raster order, one per cycle while in_stall is low. Two line
// stores share one RAM word per column, read as a pixel is taken and written
// back as it leaves the window stage, with forwarding when the same column comes
// round again at once. A pixel releases the centre up and to its left; in the
// last column and the last row it releases up to four, and the result stage
// issues one result per cycle while the output is not stalled, so such a pixel
// holds the input until its extra results are issued. A write to the width or
// height register restarts the frame at row 0, column 0; widths and heights of 0
// act as 1 and values above the maximum act as the maximum.
module window_min_max_filter_3x3_unit import wmmf_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PIX_W-1:0]     pixel,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [PIX_W-1:0]     min_value,
  output logic [PIX_W-1:0]     max_value,
  output logic [7:0]           center_row,
  output logic [7:0]           center_col,
  output logic                 last_of_run,
  output logic                 frame_done
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int DW = CW + 1;
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int HW = RW + 1;

  logic [DW-1:0] frame_width, width_cfg;
  logic [HW-1:0] frame_height, height_cfg;
  logic [CW-1:0] col_pos, col_pos_next;
  logic [RW-1:0] row_pos, row_pos_next;
  logic          last_col_in, last_row_in;
  logic [DW+CFG_W-1:0] wd_ext;
  logic [HW+CFG_W-1:0] hd_ext;

  logic          s1_valid;
  logic [3:0]    s1_pend;
  logic [CW-1:0] s1_col;
  logic [RW-1:0] s1_row;
  pix_t          s1_pixel;
  logic          fwd;
  logic [15:0]   fwd_data;
  logic [15:0]   ram_rd;
  logic [15:0]   s1_lines;

  logic [3:0]    pend_in;
  logic [3:0]    sel_onehot, rest;
  res_kind_t     kind;
  logic          out_ready, emit, s1_free, accept, retire;
  logic          c_ge1, c_ge2, r_ge1, r_ge2;
  nb_mask_t      mask;
  win_t          win;
  pcol_t         wcol0, wcol1;
  pix_t          k_min, k_max;
  logic [RW-1:0] crow;
  logic [CW-1:0] ccol;
  logic [RW+7:0] crow_ext;
  logic [CW+7:0] ccol_ext;

  // register writes
  always_comb begin
    wd_ext = {{DW{1'b0}}, cfg_data};
    hd_ext = {{HW{1'b0}}, cfg_data};
    if (cfg_data == '0) begin
      width_cfg = DW'(1);
    end else if (32'(cfg_data) > 32'(MAX_WIDTH)) begin
      width_cfg = DW'(MAX_WIDTH);
    end else begin
      width_cfg = wd_ext[DW-1:0];
    end
    if (cfg_data == '0) begin
      height_cfg = HW'(1);
    end else if (32'(cfg_data) > 32'(MAX_HEIGHT)) begin
      height_cfg = HW'(MAX_HEIGHT);
    end else begin
      height_cfg = hd_ext[HW-1:0];
    end
  end

  // position of the next pixel
  always_comb begin
    last_col_in  = (DW'({1'b0, col_pos}) + DW'(1)) == frame_width;
    last_row_in  = (HW'({1'b0, row_pos}) + HW'(1)) == frame_height;
    col_pos_next = last_col_in ? '0 : col_pos + CW'(1);
    if (!last_col_in) begin
      row_pos_next = row_pos;
    end else if (last_row_in) begin
      row_pos_next = '0;
    end else begin
      row_pos_next = row_pos + RW'(1);
    end
    pend_in[RES_UP_MID]   = (row_pos != '0) && (col_pos != '0);
    pend_in[RES_UP_LAST]  = (row_pos != '0) && last_col_in;
    pend_in[RES_LOW_MID]  = last_row_in && (col_pos != '0);
    pend_in[RES_LOW_LAST] = last_row_in && last_col_in;
  end

  // result selection in the window stage
  always_comb begin
    sel_onehot = s1_pend & (~s1_pend + 4'd1);
    rest       = s1_pend & ~sel_onehot;
    priority if (s1_pend[RES_UP_MID])  kind = RES_UP_MID;
    else if (s1_pend[RES_UP_LAST])     kind = RES_UP_LAST;
    else if (s1_pend[RES_LOW_MID])     kind = RES_LOW_MID;
    else                               kind = RES_LOW_LAST;
  end

  assign out_ready = !out_valid || !out_stall;
  assign emit      = s1_valid && (s1_pend != '0) && out_ready;
  assign s1_free   = !s1_valid || (s1_pend == '0) || (out_ready && (rest == '0));
  assign in_stall  = !s1_free;
  assign accept    = in_valid && s1_free;
  assign retire    = s1_valid && s1_free;

  assign s1_lines = fwd ? fwd_data : ram_rd;

  wmmf_line_ram #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (16)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (retire),
    .wr_addr (s1_col),
    .wr_data ({s1_lines[7:0], s1_pixel}),
    .rd_en   (accept),
    .rd_addr (col_pos),
    .rd_data (ram_rd)
  );

  always_comb begin
    c_ge1 = (s1_col != '0);
    c_ge2 = |s1_col[CW-1:1];
    r_ge1 = (s1_row != '0);
    r_ge2 = |s1_row[RW-1:1];
    win[0] = wcol0;
    win[1] = wcol1;
    win[2] = {s1_pixel, s1_lines[7:0], s1_lines[15:8]};
    unique case (kind)
      RES_UP_MID: begin
        mask.rows = r_ge2 ? 3'b111 : 3'b110;
        mask.cols = c_ge2 ? 3'b111 : 3'b110;
        crow      = s1_row - RW'(1);
        ccol      = s1_col - CW'(1);
      end
      RES_UP_LAST: begin
        mask.rows = r_ge2 ? 3'b111 : 3'b110;
        mask.cols = c_ge1 ? 3'b110 : 3'b100;
        crow      = s1_row - RW'(1);
        ccol      = s1_col;
      end
      RES_LOW_MID: begin
        mask.rows = r_ge1 ? 3'b110 : 3'b100;
        mask.cols = c_ge2 ? 3'b111 : 3'b110;
        crow      = s1_row;
        ccol      = s1_col - CW'(1);
      end
      RES_LOW_LAST: begin
        mask.rows = r_ge1 ? 3'b110 : 3'b100;
        mask.cols = c_ge1 ? 3'b110 : 3'b100;
        crow      = s1_row;
        ccol      = s1_col;
      end
      default: begin
        mask.rows = 3'b000;
        mask.cols = 3'b000;
        crow      = s1_row;
        ccol      = s1_col;
      end
    endcase
    crow_ext = {8'b0, crow};
    ccol_ext = {8'b0, ccol};
  end

  wmmf_kernel u_kernel (
    .win       (win),
    .mask      (mask),
    .min_value (k_min),
    .max_value (k_max)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= DW'(RESET_FRAME_WIDTH);
      frame_height <= HW'(RESET_FRAME_HEIGHT);
      col_pos      <= '0;
      row_pos      <= '0;
      s1_valid     <= 1'b0;
      s1_pend      <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_write && (cfg_index == REG_FRAME_WIDTH)) begin
        frame_width <= width_cfg;
      end
      if (cfg_write && (cfg_index == REG_FRAME_HEIGHT)) begin
        frame_height <= height_cfg;
      end
      if (cfg_write && ((cfg_index == REG_FRAME_WIDTH) || (cfg_index == REG_FRAME_HEIGHT))) begin
        col_pos <= '0;
        row_pos <= '0;
      end else if (accept) begin
        col_pos <= col_pos_next;
        row_pos <= row_pos_next;
      end
      if (accept) begin
        s1_valid <= 1'b1;
        s1_pend  <= pend_in;
      end else if (retire) begin
        s1_valid <= 1'b0;
        s1_pend  <= '0;
      end else if (emit) begin
        s1_pend <= rest;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col   <= col_pos;
      s1_row   <= row_pos;
      s1_pixel <= pixel;
      fwd      <= retire && (s1_col == col_pos);
      fwd_data <= {s1_lines[7:0], s1_pixel};
    end
    if (retire) begin
      wcol0 <= wcol1;
      wcol1 <= win[2];
    end
    if (emit) begin
      min_value   <= k_min;
      max_value   <= k_max;
      center_row  <= crow_ext[7:0];
      center_col  <= ccol_ext[7:0];
      last_of_run <= (rest == '0);
      frame_done  <= (kind == RES_LOW_LAST);
    end
  end

endmodule

FILE: verif/wmmf_window_check.sv
`timescale 1ns / 1ps
// Checker for the 3x3 min/max filter: predicts every result and compares what the block gives.
module wmmf_window_check import wmmf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [PIX_W-1:0]     pixel,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [PIX_W-1:0]     min_value,
  input  logic [PIX_W-1:0]     max_value,
  input  logic [7:0]           center_row,
  input  logic [7:0]           center_col,
  input  logic                 last_of_run,
  input  logic                 frame_done,
  output int                   fail_count,
  output int                   pending_results
);

  typedef struct packed {
    pix_t       min_v;
    pix_t       max_v;
    logic [7:0] row;
    logic [7:0] col;
    logic       last_run;
    logic       done;
  } window_result_t;

  window_result_t expected_q[$];
  pix_t  line_prev  [MAX_WIDTH_DEF];
  pix_t  line_prev2 [MAX_WIDTH_DEF];
  pcol_t left_col;
  pcol_t mid_col;
  int    frame_w;
  int    frame_h;
  int    row_pos;
  int    col_pos;
  int    mismatches = 0;

  function automatic int fit_dimension(logic [CFG_W-1:0] v, int maxv);
    if (v == 0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  // min and max over the rows and columns selected by the masks (bit 0 = oldest / leftmost)
  function automatic window_result_t reduce_window(win_t win, logic [2:0] rmask,
                                                   logic [2:0] cmask, int row, int col,
                                                   logic done);
    window_result_t res;
    int k;
    int j;
    res.min_v = PIX_MAX;
    res.max_v = PIX_MIN;
    for (k = 0; k < 3; k++) begin
      for (j = 0; j < 3; j++) begin
        if (cmask[k] && rmask[j]) begin
          if (win[k][j] < res.min_v) res.min_v = win[k][j];
          if (win[k][j] > res.max_v) res.max_v = win[k][j];
        end
      end
    end
    res.row      = 8'(row);
    res.col      = 8'(col);
    res.last_run = 1'b0;
    res.done     = done;
    return res;
  endfunction

  function automatic void predict_pixel(pix_t p);
    window_result_t batch [4];
    win_t       win;
    logic [2:0] cm_mid;
    logic [2:0] cm_last;
    logic [2:0] rm_up;
    logic [2:0] rm_low;
    logic       last_col;
    logic       last_row;
    int         n;
    int         c;
    int         i;
    n = 0;
    c = col_pos;
    if (c >= MAX_WIDTH_DEF) c = MAX_WIDTH_DEF - 1;
    win[0] = left_col;
    win[1] = mid_col;
    win[2] = {p, line_prev[c], line_prev2[c]};
    last_col = (c + 1 == frame_w);
    last_row = (row_pos + 1 == frame_h);
    cm_mid  = (c >= 2) ? 3'b111 : 3'b110;
    cm_last = (c >= 1) ? 3'b110 : 3'b100;
    rm_up   = (row_pos >= 2) ? 3'b111 : 3'b110;
    rm_low  = (row_pos >= 1) ? 3'b110 : 3'b100;
    if (row_pos >= 1) begin
      if (c >= 1) begin
        batch[n] = reduce_window(win, rm_up, cm_mid, row_pos - 1, c - 1, 1'b0);
        n++;
      end
      if (last_col) begin
        batch[n] = reduce_window(win, rm_up, cm_last, row_pos - 1, c, 1'b0);
        n++;
      end
    end
    if (last_row) begin
      if (c >= 1) begin
        batch[n] = reduce_window(win, rm_low, cm_mid, row_pos, c - 1, 1'b0);
        n++;
      end
      if (last_col) begin
        batch[n] = reduce_window(win, rm_low, cm_last, row_pos, c, 1'b1);
        n++;
      end
    end
    if (n > 0) batch[n-1].last_run = 1'b1;
    for (i = 0; i < n; i++) expected_q.push_back(batch[i]);
    left_col      = mid_col;
    mid_col       = win[2];
    line_prev2[c] = line_prev[c];
    line_prev[c]  = p;
    c++;
    if (c >= frame_w) begin
      c = 0;
      row_pos++;
      if (row_pos >= frame_h) row_pos = 0;
    end
    col_pos = c;
  endfunction

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      mismatches++;
      $display("%0t: %s expected %0h, got %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin : watch
    window_result_t expd;
    if (rst) begin
      frame_w  = RESET_FRAME_WIDTH;
      frame_h  = RESET_FRAME_HEIGHT;
      row_pos  = 0;
      col_pos  = 0;
      left_col = '0;
      mid_col  = '0;
      expected_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          $display("%0t: expected no item, got min %0h max %0h row %0d col %0d",
                   $time, min_value, max_value, center_row, center_col);
        end else begin
          expd = expected_q.pop_front();
          check_field("min_value", expd.min_v, min_value);
          check_field("max_value", expd.max_v, max_value);
          check_field("center_row", expd.row, center_row);
          check_field("center_col", expd.col, center_col);
          check_field("last_of_run", 8'(expd.last_run), 8'(last_of_run));
          check_field("frame_done", 8'(expd.done), 8'(frame_done));
        end
      end
      if (in_valid && !in_stall) predict_pixel(pixel);
      if (cfg_write) begin
        case (cfg_index)
          REG_FRAME_WIDTH: begin
            frame_w = fit_dimension(cfg_data, MAX_WIDTH_DEF);
            row_pos = 0;
            col_pos = 0;
          end
          REG_FRAME_HEIGHT: begin
            frame_h = fit_dimension(cfg_data, MAX_HEIGHT_DEF);
            row_pos = 0;
            col_pos = 0;
          end
          default: ;
        endcase
      end
    end
    fail_count      <= mismatches;
    pending_results <= expected_q.size();
  end

endmodule

FILE: verif/window_min_max_filter_3x3_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top for the 3x3 min/max filter: pixel stimulus, register writes and verdict.
module window_min_max_filter_3x3_unit_tb;
  import wmmf_pkg::*;

  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 8;
  localparam int IDLE_LIMIT     = 2000;
  localparam int RANDOM_ITEMS   = 40;
  localparam int PRESSURE_ITEMS = 30;
  localparam int TALL_ITEMS     = 8;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_FRAME_WIDTH;
  logic [CFG_W-1:0]     cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  pix_t                 pixel     = '0;
  logic                 out_stall = 1'b0;
  logic                 hold_req  = 1'b0;
  logic                 in_stall;
  logic                 out_valid;
  pix_t                 min_value;
  pix_t                 max_value;
  logic [7:0]           center_row;
  logic [7:0]           center_col;
  logic                 last_of_run;
  logic                 frame_done;
  int                   fail_count;
  int                   pending_results;
  int                   gap_max = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  window_min_max_filter_3x3_unit u_top (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .pixel,
    .out_valid, .out_stall, .min_value, .max_value,
    .center_row, .center_col, .last_of_run, .frame_done
  );

  wmmf_window_check u_window_check (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .pixel,
    .out_valid, .out_stall, .min_value, .max_value,
    .center_row, .center_col, .last_of_run, .frame_done,
    .fail_count, .pending_results
  );

  function automatic pix_t rand_pixel();
    case ($urandom_range(0, 7))
      0:       return PIX_MIN;
      1:       return PIX_MAX;
      2, 3:    return pix_t'($urandom_range(100, 103));
      default: return pix_t'($urandom_range(0, 255));
    endcase
  endfunction

  // valid stays high from one item to the next when no gap is drawn
  task automatic send_pixel(input pix_t p);
    int gap;
    gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel    <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0] w_data;
    logic [CFG_W-1:0] h_data;
    int cur_w;
    int cur_h;
    int count;
    int sent;
    int phase;
    int i;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // partial row at reset size, then a write restarts the frame
    for (i = 0; i < 3; i++) send_pixel(rand_pixel());
    drain_results();
    // zero sizes act as 1: every pixel is a whole frame
    write_reg(REG_FRAME_WIDTH, '0);
    write_reg(REG_FRAME_HEIGHT, '0);
    send_pixel(8'h00);
    send_pixel(8'hFF);
    drain_results();
    // spare indexes mid-frame must not restart it
    write_reg(REG_FRAME_WIDTH, 9'd3);
    write_reg(REG_FRAME_HEIGHT, 9'd2);
    send_pixel(8'h55);
    send_pixel(8'hAA);
    send_pixel(8'h00);
    drain_results();
    write_reg(REG_SPARE_A, 9'h1FF);
    write_reg(REG_SPARE_B, 9'h000);
    send_pixel(8'h80);
    send_pixel(8'h7F);
    send_pixel(8'hFF);
    drain_results();
    write_reg(REG_FRAME_WIDTH, 9'd2);
    write_reg(REG_FRAME_HEIGHT, 9'd3);
    send_pixel(8'hFF);
    send_pixel(8'h00);
    send_pixel(8'h01);
    send_pixel(8'hFE);
    send_pixel(8'h80);
    send_pixel(8'h7F);
    drain_results();

    // widest and tallest frames, oversize values clamp
    gap_max = 6;
    write_reg(REG_FRAME_WIDTH, 9'h1FF);
    write_reg(REG_FRAME_HEIGHT, 9'd1);
    for (i = 0; i < MAX_WIDTH_DEF; i++) send_pixel(rand_pixel());
    drain_results();
    gap_max = 0;
    write_reg(REG_FRAME_WIDTH, 9'd1);
    write_reg(REG_FRAME_HEIGHT, 9'h1FF);
    for (i = 0; i < TALL_ITEMS; i++) send_pixel(rand_pixel());
    drain_results();

    cur_w = 1;
    cur_h = MAX_HEIGHT_DEF;
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      w_data = ($urandom_range(0, 7) == 0) ? CFG_W'($urandom_range(0, 511))
                                           : CFG_W'($urandom_range(0, 10));
      h_data = ($urandom_range(0, 7) == 0) ? CFG_W'($urandom_range(0, 511))
                                           : CFG_W'($urandom_range(0, 8));
      if (phase == 0) begin
        // output held off while pixels keep coming, so the block backs up
        w_data  = 9'd10;
        h_data  = 9'd10;
        gap_max = 0;
        hold_req <= 1'b1;
      end else begin
        gap_max = ($urandom_range(0, 1) == 0) ? 0 : 6;
      end
      case ((phase == 0) ? 3 : $urandom_range(0, 4))
        0: write_reg(REG_FRAME_WIDTH, w_data);
        1: write_reg(REG_FRAME_HEIGHT, h_data);
        2: write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_A : REG_SPARE_B,
                     CFG_W'($urandom_range(0, 511)));
        default: begin
          write_reg(REG_FRAME_WIDTH, w_data);
          write_reg(REG_FRAME_HEIGHT, h_data);
        end
      endcase
      if (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT) begin
        if (cfg_index == REG_FRAME_HEIGHT || phase == 0)
          cur_h = (h_data == 0) ? 1 :
                  ((int'(h_data) > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : int'(h_data));
        if (cfg_index == REG_FRAME_WIDTH || phase == 0)
          cur_w = (w_data == 0) ? 1 :
                  ((int'(w_data) > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(w_data));
      end
      count = cur_w * cur_h * int'($urandom_range(1, 2)) + int'($urandom_range(0, cur_w));
      if (count > 60) count = int'($urandom_range(20, 60));
      if (phase == 0) count = PRESSURE_ITEMS;
      for (i = 0; i < count; i++) send_pixel(rand_pixel());
      sent += count;
      drain_results();
      phase++;
    end

    if (fail_count == 0 && pending_results == 0)
      $display("PASS window_min_max_filter_3x3_unit");
    else
      $display("FAIL window_min_max_filter_3x3_unit");
    $finish;
  end

  initial begin : result_sink
    int stall_cycles;
    int stall_max;
    int taken;
    bit hold_done;
    stall_max = 3;
    taken     = 0;
    hold_done = 1'b0;
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        stall_cycles = (stall_max == 0) ? 0 : $urandom_range(0, stall_max);
        if (stall_cycles > 0) begin
          out_stall <= 1'b1;
          repeat (stall_cycles) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
      if (taken % 40 == 0) stall_max = ($urandom_range(0, 2) == 0) ? 0 : 6;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write || rst)
        quiet = 0;
      else
        quiet++;
    end
    $display("FAIL window_min_max_filter_3x3_unit");
    $finish;
  end

endmodule
